// File: src/edfu_pkg.sv
package edfu_pkg;

	localparam int MAX_DIM = 256;
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int CNT_W   = DIM_W + 1;
	localparam int ADDR_W  = 2 * DIM_W;
	localparam int PIX_W   = ADDR_W + 1;
	localparam int DIST_W  = ADDR_W + 2;
	localparam int ROOT_W  = (DIST_W + 16) / 2;
	localparam int NUM_W   = DIST_W + 1;
	localparam int DEN_W   = CNT_W + 1;
	localparam int PROD_W  = NUM_W + DEN_W + 1;
	localparam int QUO_W   = ROOT_W + 9;

	localparam logic [DIST_W-1:0] FAR        = DIST_W'(2 * MAX_DIM * MAX_DIM);
	localparam logic [7:0]        THR_RESET  = 8'd240;
	localparam logic [7:0]        BYTE_MAX   = 8'd255;

	localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD    = 2'd2;

	typedef enum logic [5:0] {
		CMD_NOP, CMD_LOAD, CMD_READ, CMD_FILL, CMD_PINIT, CMD_LRD, CMD_LWR,
		CMD_FINIT, CMD_F1, CMD_F2, CMD_K1, CMD_K2, CMD_K3, CMD_K4, CMD_K5, CMD_K6,
		CMD_BINIT, CMD_B1, CMD_B2, CMD_B4, CMD_B5, CMD_B6, CMD_PNEXT,
		CMD_RINIT, CMD_R1, CMD_R2, CMD_R3, CMD_TDONE,
		CMD_Q1, CMD_Q2, CMD_Q3, CMD_Q4, CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic fill_end;
		logic last_q;
		logic len_one;
		logic pop;
		logic adv_ok;
		logic adv;
		logic pass_last;
		logic row_phase;
		logic root_done;
		logic quo_done;
		logic last_i;
	} stat_t;

endpackage

// File: src/edfu_sqrt.sv
module edfu_sqrt import edfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int STEP_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  x_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;

	assign rem_n = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			rem_q <= '0;
			root  <= '0;
			cnt_q <= '0;
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				x_q   <= {rad, {(RAD_W-DIST_W){1'b0}}};
				rem_q <= '0;
				root  <= '0;
				cnt_q <= STEP_W'(ROOT_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (rem_n >= trial) begin
					rem_q <= rem_n - trial;
					root  <= {root[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					root  <= {root[ROOT_W-2:0], 1'b0};
				end
				x_q   <= x_q << 2;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule

// File: src/edfu_div.sv
module edfu_div import edfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QUO_W-1:0]  num,
	input  logic [ROOT_W-1:0] den,
	output logic              done,
	output logic [QUO_W-1:0]  quo
);

	localparam int STEP_W = $clog2(QUO_W + 1);

	logic [ROOT_W-1:0] den_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W:0]   rem_n;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;

	assign rem_n = {rem_q, quo[QUO_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= '0;
			rem_q <= '0;
			quo   <= '0;
			cnt_q <= '0;
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				den_q <= den;
				rem_q <= '0;
				quo   <= num;
				cnt_q <= STEP_W'(QUO_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (rem_n >= {1'b0, den_q}) begin
					rem_q <= ROOT_W'(rem_n - {1'b0, den_q});
					quo   <= {quo[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_n[ROOT_W-1:0];
					quo   <= {quo[QUO_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule

// File: src/edfu_dp.sv
module edfu_dp import edfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic [7:0]        pixel,
	output logic              done,
	output logic [7:0]        value,
	output logic [ADDR_W-1:0] index,
	output logic              last_res
);

	logic [CNT_W-1:0] rw_q, ih_q, w, h;
	logic [7:0]       thr_q;
	logic [PIX_W-1:0] n, lp_q, rp_q, i_q, rp_eff, rp_inc, rp_nxt;

	logic                     row_q, first_q;
	logic [CNT_W-1:0]         p_q, len_q, stride_q, q_q;
	logic [ADDR_W-1:0]        base_q, addr_q, pinit_base;
	logic [DIM_W-1:0]         k_q, top_q, v_q, absd;
	logic [DIST_W-1:0]        fq_q, b_val;
	logic signed [NUM_W-1:0]  num_q, bn_q;
	logic [DEN_W-1:0]         den_q, bd_q, den_n;
	logic signed [PROD_W-1:0] p1_q, p2_q, bn_x, qbd_x;
	logic [ROOT_W-1:0]        rmin_q, rmax_q, root_q, rr, span, diff;
	logic [2*DIM_W-1:0]       qsq, vsq, bsq;
	logic [DIM_W+DEN_W-1:0]   qbd;
	logic [DIM_W+CNT_W-1:0]   pw;
	logic [NUM_W-1:0]         fv, num_n;
	logic [CNT_W-1:0]         dq;
	logic [QUO_W-1:0]         dnum, quo;
	logic                     root_done, quo_done;
	logic [ROOT_W-1:0]        root_out;

	logic [DIST_W-1:0] dist_mem [2**ADDR_W];
	logic [DIST_W-1:0] dist_rd_q, dist_wd;
	logic [ADDR_W-1:0] dist_wa, dist_ra;
	logic              dist_we;

	logic [DIST_W-1:0] lb_mem [MAX_DIM];
	logic [DIST_W-1:0] lb_rd_q;
	logic [DIM_W-1:0]  lb_ra;
	logic              lb_we;

	logic [DIM_W-1:0]  env_mem [MAX_DIM];
	logic [DIM_W-1:0]  env_rd_q, env_wa, env_wd;
	logic              env_we;

	logic signed [NUM_W-1:0] bn_mem [MAX_DIM];
	logic [DEN_W-1:0]        bd_mem [MAX_DIM];
	logic signed [NUM_W-1:0] bn_rd_q;
	logic [DEN_W-1:0]        bd_rd_q;
	logic [DIM_W-1:0]        bnd_ra;
	logic                    bnd_we;

	always_comb begin
		w = rw_q;
		if (rw_q == '0) begin
			w = CNT_W'(1);
		end else if (rw_q > CNT_W'(MAX_DIM)) begin
			w = CNT_W'(MAX_DIM);
		end
		h = ih_q;
		if (ih_q == '0) begin
			h = CNT_W'(1);
		end else if (ih_q > CNT_W'(MAX_DIM)) begin
			h = CNT_W'(MAX_DIM);
		end
	end

	assign n      = PIX_W'(w * h);
	assign rp_eff = (rp_q >= n) ? '0 : rp_q;
	assign rp_inc = rp_q + 1'b1;
	assign rp_nxt = (rp_inc >= n) ? '0 : rp_inc;

	assign qsq   = q_q[DIM_W-1:0] * q_q[DIM_W-1:0];
	assign vsq   = v_q * v_q;
	assign fv    = NUM_W'(lb_rd_q) + NUM_W'(vsq);
	assign num_n = NUM_W'(fq_q) - fv;
	assign dq    = q_q - CNT_W'(v_q);
	assign den_n = {dq, 1'b0};
	assign qbd   = q_q[DIM_W-1:0] * bd_rd_q;
	assign bn_x  = PROD_W'(bn_rd_q);
	assign qbd_x = PROD_W'(qbd);
	assign absd  = (q_q[DIM_W-1:0] >= v_q) ? (q_q[DIM_W-1:0] - v_q) : (v_q - q_q[DIM_W-1:0]);
	assign bsq   = absd * absd;
	assign b_val = lb_rd_q + DIST_W'(bsq);
	assign pw    = p_q[DIM_W-1:0] * w;

	assign pinit_base = row_q ? ADDR_W'(pw) : ADDR_W'(p_q);

	assign span = rmax_q - rmin_q;
	assign rr   = (root_q < rmin_q) ? rmin_q : ((root_q > rmax_q) ? rmax_q : root_q);
	assign diff = rr - rmin_q;
	assign dnum = QUO_W'({diff, 8'b0}) - QUO_W'(diff) + QUO_W'(span) - 1'b1;

	always_comb begin
		stat.fill_end  = lp_q >= n;
		stat.last_q    = q_q == len_q - 1'b1;
		stat.len_one   = len_q == CNT_W'(1);
		stat.pop       = (k_q != '0) && (p1_q <= p2_q);
		stat.adv_ok    = k_q < top_q;
		stat.adv       = bn_x < qbd_x;
		stat.pass_last = row_q ? (p_q == h - 1'b1) : (p_q == w - 1'b1);
		stat.row_phase = row_q;
		stat.root_done = root_done;
		stat.quo_done  = quo_done;
		stat.last_i    = i_q == n - 1'b1;
	end

	always_comb begin
		dist_we = 1'b0;
		dist_wa = lp_q[ADDR_W-1:0];
		dist_wd = FAR;
		dist_ra = addr_q;
		case (cmd)
			CMD_LOAD: begin
				dist_we = lp_q < n;
				dist_wd = (pixel > thr_q) ? '0 : FAR;
			end
			CMD_FILL: begin
				dist_we = lp_q < n;
			end
			CMD_B6: begin
				dist_we = 1'b1;
				dist_wa = addr_q;
				dist_wd = b_val;
			end
			CMD_R1: begin
				dist_ra = i_q[ADDR_W-1:0];
			end
			CMD_READ: begin
				dist_ra = rp_eff[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign lb_we  = cmd == CMD_LWR;
	assign lb_ra  = (cmd == CMD_F1) ? q_q[DIM_W-1:0] : env_rd_q;
	assign env_we = (cmd == CMD_FINIT) || (cmd == CMD_K6);
	assign env_wa = (cmd == CMD_FINIT) ? '0 : k_q;
	assign env_wd = (cmd == CMD_FINIT) ? '0 : q_q[DIM_W-1:0];
	assign bnd_we = cmd == CMD_K6;
	assign bnd_ra = (cmd == CMD_B1) ? k_q + 1'b1 : k_q;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_rd_q <= dist_mem[dist_ra];
	end

	always_ff @(posedge clk) begin
		if (lb_we) begin
			lb_mem[q_q[DIM_W-1:0]] <= dist_rd_q;
		end
		lb_rd_q <= lb_mem[lb_ra];
	end

	always_ff @(posedge clk) begin
		if (env_we) begin
			env_mem[env_wa] <= env_wd;
		end
		env_rd_q <= env_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (bnd_we) begin
			bn_mem[k_q] <= num_q;
			bd_mem[k_q] <= den_q;
		end
		bn_rd_q <= bn_mem[bnd_ra];
		bd_rd_q <= bd_mem[bnd_ra];
	end

	edfu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((cmd == CMD_R2) || (cmd == CMD_Q1)),
		.rad    (dist_rd_q),
		.done   (root_done),
		.root   (root_out)
	);

	edfu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd == CMD_Q3),
		.num    (dnum),
		.den    (span),
		.done   (quo_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw_q     <= CNT_W'(MAX_DIM);
			ih_q     <= CNT_W'(MAX_DIM);
			thr_q    <= THR_RESET;
			lp_q     <= '0;
			rp_q     <= '0;
			i_q      <= '0;
			row_q    <= 1'b0;
			first_q  <= 1'b0;
			p_q      <= '0;
			len_q    <= '0;
			stride_q <= '0;
			base_q   <= '0;
			addr_q   <= '0;
			q_q      <= '0;
			k_q      <= '0;
			top_q    <= '0;
			v_q      <= '0;
			fq_q     <= '0;
			num_q    <= '0;
			den_q    <= '0;
			bn_q     <= '0;
			bd_q     <= '0;
			p1_q     <= '0;
			p2_q     <= '0;
			rmin_q   <= '0;
			rmax_q   <= '0;
			root_q   <= '0;
			done     <= 1'b0;
			value    <= '0;
			index    <= '0;
			last_res <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_WIDTH:    rw_q  <= cfg_data;
					REG_IMAGE_HEIGHT: ih_q  <= cfg_data;
					REG_THRESHOLD:    thr_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			case (cmd)
				CMD_LOAD: begin
					if (lp_q < n) begin
						lp_q <= lp_q + 1'b1;
					end
				end
				CMD_FILL: begin
					row_q <= 1'b0;
					p_q   <= '0;
					if (lp_q < n) begin
						lp_q <= lp_q + 1'b1;
					end
				end
				CMD_PINIT: begin
					len_q    <= row_q ? w : h;
					stride_q <= row_q ? CNT_W'(1) : w;
					base_q   <= pinit_base;
					addr_q   <= pinit_base;
					q_q      <= '0;
				end
				CMD_LWR: begin
					addr_q <= addr_q + ADDR_W'(stride_q);
					q_q    <= q_q + 1'b1;
				end
				CMD_FINIT: begin
					k_q <= '0;
					q_q <= CNT_W'(1);
				end
				CMD_F2: begin
					fq_q <= lb_rd_q + DIST_W'(qsq);
				end
				CMD_K2: begin
					v_q  <= env_rd_q;
					bn_q <= bn_rd_q;
					bd_q <= bd_rd_q;
				end
				CMD_K3: begin
					num_q <= num_n;
					den_q <= den_n;
				end
				CMD_K4: begin
					p1_q <= num_q * $signed({1'b0, bd_q});
					p2_q <= bn_q * $signed({1'b0, den_q});
				end
				CMD_K5: begin
					if (stat.pop) begin
						k_q <= k_q - 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				CMD_K6: begin
					q_q <= q_q + 1'b1;
				end
				CMD_BINIT: begin
					top_q  <= k_q;
					k_q    <= '0;
					q_q    <= '0;
					addr_q <= base_q;
				end
				CMD_B2: begin
					if (stat.adv) begin
						k_q <= k_q + 1'b1;
					end
				end
				CMD_B5: begin
					v_q <= env_rd_q;
				end
				CMD_B6: begin
					addr_q <= addr_q + ADDR_W'(stride_q);
					q_q    <= q_q + 1'b1;
				end
				CMD_PNEXT: begin
					if (stat.pass_last && !row_q) begin
						row_q <= 1'b1;
						p_q   <= '0;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				CMD_RINIT: begin
					i_q     <= '0;
					first_q <= 1'b1;
				end
				CMD_R3: begin
					if (root_done) begin
						if (first_q || (root_out < rmin_q)) begin
							rmin_q <= root_out;
						end
						if (first_q || (root_out > rmax_q)) begin
							rmax_q <= root_out;
						end
						first_q <= 1'b0;
						i_q     <= i_q + 1'b1;
					end
				end
				CMD_TDONE: begin
					lp_q <= '0;
					rp_q <= '0;
				end
				CMD_READ: begin
					rp_q <= rp_eff;
				end
				CMD_Q2: begin
					if (root_done) begin
						root_q <= root_out;
					end
				end
				CMD_OUT: begin
					done     <= 1'b1;
					value    <= (rmax_q > rmin_q) ? (BYTE_MAX - quo[7:0]) : '0;
					index    <= rp_q[ADDR_W-1:0];
					last_res <= rp_q == n - 1'b1;
					rp_q     <= rp_nxt;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/edfu_ctrl.sv
module edfu_ctrl import edfu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  op,
	input  logic  last,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_FILL, ST_PINIT, ST_LRD, ST_LWR, ST_FINIT, ST_F1, ST_F2,
		ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6,
		ST_BINIT, ST_B1, ST_B2, ST_B4, ST_B5, ST_B6, ST_PNEXT,
		ST_RINIT, ST_R1, ST_R2, ST_R3, ST_TDONE,
		ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_OUT
	} state_t;

	state_t state_q;

	assign busy = state_q != ST_IDLE;

	always_comb begin
		case (state_q)
			ST_IDLE:  cmd = start ? (op ? CMD_READ : CMD_LOAD) : CMD_NOP;
			ST_FILL:  cmd = CMD_FILL;
			ST_PINIT: cmd = CMD_PINIT;
			ST_LRD:   cmd = CMD_LRD;
			ST_LWR:   cmd = CMD_LWR;
			ST_FINIT: cmd = CMD_FINIT;
			ST_F1:    cmd = CMD_F1;
			ST_F2:    cmd = CMD_F2;
			ST_K1:    cmd = CMD_K1;
			ST_K2:    cmd = CMD_K2;
			ST_K3:    cmd = CMD_K3;
			ST_K4:    cmd = CMD_K4;
			ST_K5:    cmd = CMD_K5;
			ST_K6:    cmd = CMD_K6;
			ST_BINIT: cmd = CMD_BINIT;
			ST_B1:    cmd = CMD_B1;
			ST_B2:    cmd = CMD_B2;
			ST_B4:    cmd = CMD_B4;
			ST_B5:    cmd = CMD_B5;
			ST_B6:    cmd = CMD_B6;
			ST_PNEXT: cmd = CMD_PNEXT;
			ST_RINIT: cmd = CMD_RINIT;
			ST_R1:    cmd = CMD_R1;
			ST_R2:    cmd = CMD_R2;
			ST_R3:    cmd = CMD_R3;
			ST_TDONE: cmd = CMD_TDONE;
			ST_Q1:    cmd = CMD_Q1;
			ST_Q2:    cmd = CMD_Q2;
			ST_Q3:    cmd = CMD_Q3;
			ST_Q4:    cmd = CMD_Q4;
			ST_OUT:   cmd = CMD_OUT;
			default:  cmd = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (op) begin
							state_q <= ST_Q1;
						end else if (last) begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL:  state_q <= stat.fill_end ? ST_PINIT : ST_FILL;
				ST_PINIT: state_q <= ST_LRD;
				ST_LRD:   state_q <= ST_LWR;
				ST_LWR:   state_q <= stat.last_q ? ST_FINIT : ST_LRD;
				ST_FINIT: state_q <= stat.len_one ? ST_BINIT : ST_F1;
				ST_F1:    state_q <= ST_F2;
				ST_F2:    state_q <= ST_K1;
				ST_K1:    state_q <= ST_K2;
				ST_K2:    state_q <= ST_K3;
				ST_K3:    state_q <= ST_K4;
				ST_K4:    state_q <= ST_K5;
				ST_K5:    state_q <= stat.pop ? ST_K1 : ST_K6;
				ST_K6:    state_q <= stat.last_q ? ST_BINIT : ST_F1;
				ST_BINIT: state_q <= ST_B1;
				ST_B1:    state_q <= stat.adv_ok ? ST_B2 : ST_B4;
				ST_B2:    state_q <= stat.adv ? ST_B1 : ST_B4;
				ST_B4:    state_q <= ST_B5;
				ST_B5:    state_q <= ST_B6;
				ST_B6:    state_q <= stat.last_q ? ST_PNEXT : ST_B1;
				ST_PNEXT: state_q <= (stat.pass_last && stat.row_phase) ? ST_RINIT : ST_PINIT;
				ST_RINIT: state_q <= ST_R1;
				ST_R1:    state_q <= ST_R2;
				ST_R2:    state_q <= ST_R3;
				ST_R3: begin
					if (stat.root_done) begin
						state_q <= stat.last_i ? ST_TDONE : ST_R1;
					end
				end
				ST_TDONE: state_q <= ST_IDLE;
				ST_Q1:    state_q <= ST_Q2;
				ST_Q2:    state_q <= stat.root_done ? ST_Q3 : ST_Q2;
				ST_Q3:    state_q <= ST_Q4;
				ST_Q4:    state_q <= stat.quo_done ? ST_OUT : ST_Q4;
				ST_OUT:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/euclidean_distance_field_unit.sv
// Distance field of an 8-bit image with byte results.
// An item is taken when start is high and busy is low. With op low it loads one
// pixel in row-major order; pixels above the threshold are features. A load
// with last high fills any missing pixels as non-features and runs the
// transform: a column pass and a row pass of exact parabola envelopes, then a
// square root of every squared distance to find the minimum and maximum.
// Busy stays high through the transform; the roots are taken one after another
// by the bit-serial root unit, reading the distance memory through one port.
// With op high the next result pixel is read: a root and a serial division give
// the byte, shown with done for one cycle.
// The receiver cannot stall; done lasts exactly one cycle per result.
// The user must write configuration through cfg_we, cfg_index and cfg_data only while idle;
// the block does not enforce this. Reset restores the register defaults and
// clears the pointers and the extrema; the distance memory keeps whatever it held.
module euclidean_distance_field_unit import edfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [7:0]        pixel,
	input  logic              last,
	output logic              done,
	output logic [7:0]        value,
	output logic [ADDR_W-1:0] index,
	output logic              last_res,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	edfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.last   (last),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	edfu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.done      (done),
		.value     (value),
		.index     (index),
		.last_res  (last_res)
	);

endmodule

// File: sim/euclidean_distance_field_unit_tb.sv
`timescale 1ns / 100ps

module euclidean_distance_field_unit_tb;
	import edfu_pkg::*;

	typedef struct {
		logic       op;
		logic [7:0] pixel;
		logic       last;
	} cmd_item_t;

	typedef struct {
		logic [7:0]        value;
		logic [ADDR_W-1:0] index;
		logic              last_res;
	} field_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              op = 1'b0;
	logic [7:0]        pixel = 8'd0;
	logic              last = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_ROW_WIDTH;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              busy;
	logic              done;
	logic [7:0]        value;
	logic [ADDR_W-1:0] index;
	logic              last_res;

	cmd_item_t   pending_cmds[$];
	field_byte_t expected_bytes[$];
	int          idle_pct = 0;
	int          errors = 0;
	int          items_sent = 0;
	int          bytes_seen = 0;
	int          transforms_run = 0;

	// Shadow of the block: registers, squared distances and the envelope scratch.
	int unsigned       reg_w = 256, reg_h = 256, reg_thr = 240;
	logic [DIST_W-1:0] sq_dist [MAX_DIM*MAX_DIM];
	bit                written [MAX_DIM*MAX_DIM];
	longint            line_val [MAX_DIM];
	int                env_pos [MAX_DIM];
	longint            bnd_num [MAX_DIM+1];
	longint            bnd_den [MAX_DIM+1];
	longint unsigned   root_lo = 0, root_hi = 0;
	int unsigned       load_ptr = 0, read_ptr = 0;

	euclidean_distance_field_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.pixel(pixel), .last(last), .done(done), .value(value), .index(index),
		.last_res(last_res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned dim_of(int unsigned v);
		if (v < 1) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic longint unsigned root_q8(longint unsigned d);
		longint unsigned x, r, b;
		x = d << 16;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic envelope_line(int n, int base, int stride);
		int k, q, v, top;
		longint num, den, diff;
		k = 0;
		env_pos[0] = 0;
		for (q = 1; q < n; q++) begin
			forever begin
				v = env_pos[k];
				num = (line_val[q] + longint'(q) * q) - (line_val[v] + longint'(v) * v);
				den = 2 * (longint'(q) - v);
				if (k > 0 && num * bnd_den[k] <= bnd_num[k] * den) k--;
				else break;
			end
			k++;
			env_pos[k] = q;
			bnd_num[k] = num;
			bnd_den[k] = den;
		end
		top = k;
		k = 0;
		for (q = 0; q < n; q++) begin
			while (k < top && bnd_num[k+1] < longint'(q) * bnd_den[k+1]) k++;
			v = env_pos[k];
			diff = longint'(q) - v;
			sq_dist[base + q*stride] = DIST_W'(diff * diff + line_val[v]);
			written[base + q*stride] = 1'b1;
		end
	endtask

	task automatic run_transform(int w, int h);
		int x, y, i;
		longint unsigned r;
		for (x = 0; x < w; x++) begin
			for (y = 0; y < h; y++) line_val[y] = sq_dist[y*w + x];
			envelope_line(h, x, w);
		end
		for (y = 0; y < h; y++) begin
			for (x = 0; x < w; x++) line_val[x] = sq_dist[y*w + x];
			envelope_line(w, y*w, 1);
		end
		root_lo = root_q8(sq_dist[0]);
		root_hi = root_lo;
		for (i = 1; i < w*h; i++) begin
			r = root_q8(sq_dist[i]);
			if (r < root_lo) root_lo = r;
			if (r > root_hi) root_hi = r;
		end
		transforms_run++;
	endtask

	function automatic int unsigned pixel_count();
		return dim_of(reg_w) * dim_of(reg_h);
	endfunction

	task automatic queue_load(logic [7:0] px, logic lst);
		cmd_item_t c;
		int unsigned n, i;
		n = pixel_count();
		c.op = 1'b0;
		c.pixel = px;
		c.last = lst;
		pending_cmds.push_back(c);
		items_sent++;
		if (load_ptr < n) begin
			sq_dist[load_ptr] = (px > reg_thr) ? '0 : FAR;
			written[load_ptr] = 1'b1;
			load_ptr++;
		end
		if (lst) begin
			for (i = load_ptr; i < n; i++) begin
				sq_dist[i] = FAR;
				written[i] = 1'b1;
			end
			run_transform(dim_of(reg_w), dim_of(reg_h));
			load_ptr = 0;
			read_ptr = 0;
		end
	endtask

	// A read of a never written distance would be undefined, so it is skipped.
	task automatic queue_read();
		cmd_item_t c;
		field_byte_t e;
		int unsigned n, p;
		longint unsigned r, span, up;
		n = pixel_count();
		p = (read_ptr >= n) ? 0 : read_ptr;
		if (!written[p]) return;
		read_ptr = p;
		c.op = 1'b1;
		c.pixel = 8'($urandom);
		c.last = 1'($urandom);
		pending_cmds.push_back(c);
		items_sent++;
		r = root_q8(sq_dist[read_ptr]);
		e.value = 8'd0;
		if (root_hi > root_lo) begin
			span = root_hi - root_lo;
			if (r < root_lo) r = root_lo;
			if (r > root_hi) r = root_hi;
			up = ((r - root_lo) * 255 + span - 1) / span;
			e.value = 8'(255 - up);
		end
		e.index = ADDR_W'(read_ptr);
		e.last_res = (read_ptr == n - 1);
		expected_bytes.push_back(e);
		read_ptr++;
		if (read_ptr >= n) read_ptr = 0;
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CNT_W'(data);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROW_WIDTH) reg_w = data & 9'h1FF;
		else if (idx == REG_IMAGE_HEIGHT) reg_h = data & 9'h1FF;
		else if (idx == REG_THRESHOLD) reg_thr = data & 8'hFF;
	endtask

	task automatic setup(int unsigned w, int unsigned h, int unsigned thr);
		write_reg(REG_ROW_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_THRESHOLD, thr);
	endtask

	task automatic drain();
		int quiet;
		while (pending_cmds.size() != 0 || start) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		quiet = 0;
		while (quiet < 64) begin
			@(posedge clk);
			quiet = busy ? 0 : quiet + 1;
		end
	endtask

	task automatic random_image();
		int unsigned n, loads, i, mode, feat;
		n = pixel_count();
		mode = $urandom_range(0, 5);
		feat = $urandom_range(0, 40);
		loads = (mode == 0) ? $urandom_range(1, n) : (mode == 1) ? n + $urandom_range(1, 3) : n;
		for (i = 0; i < loads; i++) begin
			if ($urandom_range(0, 15) == 0) queue_read();
			queue_load(($urandom_range(0, 99) < feat) ? 8'd255 : 8'($urandom),
				i == loads - 1);
		end
		for (i = $urandom_range(0, n + 3); i > 0; i--) queue_read();
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmd_item_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (pending_cmds.size() != 0 && $urandom_range(1, 100) > idle_pct) begin
				c = pending_cmds.pop_front();
				start <= 1'b1;
				op <= c.op;
				pixel <= c.pixel;
				last <= c.last;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		field_byte_t e;
		if (arst_n && done) begin
			bytes_seen++;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result value %0d index %0d", $time, value, index);
				errors++;
			end else begin
				e = expected_bytes.pop_front();
				if (value !== e.value) begin
					$display("%0t: value expected %0d actual %0d", $time, e.value, value);
					errors++;
				end
				if (index !== e.index) begin
					$display("%0t: index expected %0d actual %0d", $time, e.index, index);
					errors++;
				end
				if (last_res !== e.last_res) begin
					$display("%0t: last_res expected %0b actual %0b", $time, e.last_res,
						last_res);
					errors++;
				end
			end
		end
	end

	initial begin
		int i, ph;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		setup(3, 2, 240);
		queue_load(8'd0, 1'b0);
		queue_read();
		queue_load(8'd255, 1'b0);
		queue_load(8'd241, 1'b0);
		queue_load(8'd240, 1'b0);
		queue_load(8'd0, 1'b0);
		queue_load(8'd128, 1'b1);
		for (i = 0; i < 7; i++) queue_read();
		queue_load(8'd255, 1'b0);
		queue_load(8'd3, 1'b1);
		for (i = 0; i < 6; i++) queue_read();
		drain();

		setup(0, 511, 0);
		for (i = 0; i < 258; i++) queue_load(8'(i), i == 257);
		for (i = 0; i < 20; i++) queue_read();
		drain();

		setup(256, 1, 255);
		for (i = 0; i < 5; i++) queue_load(8'd255, i == 4);
		for (i = 0; i < 6; i++) queue_read();
		drain();

		ph = 0;
		while (items_sent < 550 || ph < 4) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 81;
				2: idle_pct = 0;
				default: idle_pct = 24;
			endcase
			setup($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 255));
			if ($urandom_range(0, 1)) queue_read();
			random_image();
			drain();
			ph++;
		end

		$display("Sent %0d items over %0d transforms and checked %0d result bytes.",
			items_sent, transforms_run, bytes_seen);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#(64'd40_000_000);
		$display("Timeout with %0d results outstanding.", expected_bytes.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
src/edfu_pkg.sv
src/edfu_sqrt.sv
src/edfu_div.sv
src/edfu_dp.sv
src/edfu_ctrl.sv
src/euclidean_distance_field_unit.sv
sim/euclidean_distance_field_unit_tb.sv
